/* hdl/smts_pkg.sv */
`timescale 1ns / 1ps

package smts_pkg;

	localparam int STAMP_W  = 64;
	localparam int FREQ_W   = 32;
	localparam int TARGET_W = 34;
	localparam int PROD_W   = FREQ_W + TARGET_W;
	localparam int CNT_W    = 6;
	localparam int CFG_IDX_W = 2;

	typedef logic [STAMP_W-1:0]  stamp_t;
	typedef logic [FREQ_W-1:0]   freq_t;
	typedef logic [TARGET_W-1:0] target_t;
	typedef logic [PROD_W-1:0]   prod_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_REF_FREQ   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_START  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_HZ  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STAMP_BASE = 2'd3;

	localparam target_t TARGET_HZ_RESET = 34'd2400000000;

endpackage

/* hdl/scaled_monotonic_timestamp.sv */
`timescale 1ns / 1ps
// Scaled monotonic timestamp.
// The sample channel (sample_valid, sample_stall, ref_sample, sample_ok) takes
// one counter reading per word; the stamp channel (stamp_valid, stamp_stall,
// stamp) returns exactly one stamp word for each sample word, in order.
// The config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// ref_freq, ref_start, target_hz and stamp_base; cfg_ready is always high and
// writes are meant for times when no sample is in flight.
// With ref_freq zero or sample_ok low, the stamp appears in the cycle after
// the sample is taken, and such words can follow each other every cycle while
// stamp_stall is low. Otherwise the elapsed count is divided by ref_freq, the
// remainder scaled and divided again, and the parts summed: two 64-step
// restoring divisions on the shared subtractor and the 32x34 multiplier, then the
// final add and compare. The next sample can be taken in the same cycle
// that stamp_valid rises, if stamp_stall is low. One sample is in work at a
// time, and sample_stall also stays high while a finished stamp waits under
// stamp_stall.
// Reset clears the last stamp and the registers to their reset values
// (target_hz to 2400000000) and leaves the block idle with no stamp pending.
module scaled_monotonic_timestamp
	import smts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic [63:0]          ref_sample,
	input  logic                 sample_ok,
	output logic                 stamp_valid,
	input  logic                 stamp_stall,
	output logic [63:0]          stamp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV1  = 3'd1;
	localparam logic [2:0] S_MUL1  = 3'd2;
	localparam logic [2:0] S_DIV2  = 3'd3;
	localparam logic [2:0] S_MULLO = 3'd4;
	localparam logic [2:0] S_MULHI = 3'd5;
	localparam logic [2:0] S_SUM   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]     state_q;
	logic [CNT_W-1:0] cnt_q;
	freq_t          freq_q;
	stamp_t         start_q;
	target_t        target_q;
	stamp_t         base_q;
	stamp_t         last_q;
	stamp_t         work_q;
	freq_t          rem_q;
	stamp_t         quo_q;
	stamp_t         prod_q;
	stamp_t         acc_q;
	logic           out_valid_q;
	stamp_t         stamp_q;

	logic           take;
	logic           fallback;
	logic           out_free;
	logic           cfg_wr;
	logic           stamp_set;
	logic [FREQ_W:0]   trial;
	logic [FREQ_W+1:0] diff;
	logic           ge;
	freq_t          rem_n;
	freq_t          mul_a;
	prod_t          mul_p;
	stamp_t         t_sum;

	assign out_free     = !out_valid_q || !stamp_stall;
	assign sample_stall = (state_q != S_IDLE) || !out_free;
	assign take         = sample_valid && !sample_stall;
	assign fallback     = (freq_q == '0) || !sample_ok;
	assign cfg_ready    = 1'b1;
	assign cfg_wr       = cfg_valid && cfg_ready;
	assign stamp_valid  = out_valid_q;
	assign stamp        = stamp_q;
	assign stamp_set    = (state_q == S_IDLE && take && fallback) ||
	                      (state_q == S_DONE && out_free);

	// One restoring division step, shared by both divisions.
	assign trial = {rem_q, work_q[STAMP_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, freq_q};
	assign ge    = !diff[FREQ_W+1];
	assign rem_n = ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];

	// Shared multiplier operand: remainder first, then the quotient halves.
	always_comb begin
		unique case (state_q)
			S_MULLO: mul_a = quo_q[FREQ_W-1:0];
			S_MULHI: mul_a = quo_q[STAMP_W-1:FREQ_W];
			default: mul_a = rem_q;
		endcase
	end
	assign mul_p = {{TARGET_W{1'b0}}, mul_a} * {{FREQ_W{1'b0}}, target_q};

	assign t_sum = acc_q + base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			freq_q      <= '0;
			start_q     <= '0;
			target_q    <= TARGET_HZ_RESET;
			base_q      <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (stamp_set) begin
				out_valid_q <= 1'b1;
			end else if (!stamp_stall) begin
				out_valid_q <= 1'b0;
			end
			// A stamp_base write reloads the last stamp and overrides any update.
			if (cfg_wr && cfg_index == REG_STAMP_BASE) begin
				last_q <= cfg_data;
			end else if (state_q == S_IDLE && take && fallback) begin
				last_q <= last_q + 64'd1;
			end else if (state_q == S_DONE && out_free && t_sum > last_q) begin
				last_q <= t_sum;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take && !fallback) begin
						state_q <= S_DIV1;
						cnt_q   <= '0;
					end
				end
				S_DIV1: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					state_q <= S_DIV2;
					cnt_q   <= '0;
				end
				S_DIV2: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) begin
						state_q <= S_MULLO;
					end
				end
				S_MULLO: state_q <= S_MULHI;
				S_MULHI: state_q <= S_SUM;
				S_SUM:   state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_REF_FREQ:   freq_q   <= cfg_data[FREQ_W-1:0];
					REG_REF_START:  start_q  <= cfg_data;
					REG_TARGET_HZ:  target_q <= cfg_data[TARGET_W-1:0];
					REG_STAMP_BASE: base_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					work_q  <= ref_sample - start_q;
					rem_q   <= '0;
					stamp_q <= last_q;
				end
			end
			S_DIV1, S_DIV2: begin
				work_q <= {work_q[STAMP_W-2:0], ge};
				rem_q  <= rem_n;
			end
			S_MUL1: begin
				quo_q  <= work_q;
				work_q <= mul_p[STAMP_W-1:0];
				rem_q  <= '0;
			end
			S_MULLO: prod_q <= mul_p[STAMP_W-1:0];
			S_MULHI: begin
				acc_q  <= work_q + prod_q;
				prod_q <= mul_p[STAMP_W-1:0];
			end
			S_SUM: acc_q <= acc_q + {prod_q[FREQ_W-1:0], {FREQ_W{1'b0}}};
			S_DONE: begin
				if (out_free) begin
					stamp_q <= (t_sum > last_q) ? t_sum : last_q;
				end
			end
			default: ;
		endcase
	end

	// The partial remainder stays below the divisor throughout a division.
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV1 || state_q == S_DIV2) |-> (rem_q < freq_q))
		else $error("partial remainder not below divisor");

	// A computed stamp leaves the last stamp equal to the word shown.
	a_done_tracks_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free && !cfg_wr) |=> (stamp_valid && last_q == stamp_q))
		else $error("last stamp differs from delivered stamp");

	// The fallback shows the old stamp and steps the last stamp by one.
	a_fallback_step: assert property (@(posedge clk) disable iff (!arst_n)
		(take && fallback && !(cfg_wr && cfg_index == REG_STAMP_BASE))
		|=> (stamp_valid && last_q == stamp_q + 64'd1))
		else $error("fallback increment wrong");

	// The divider starts only from an accepted sample.
	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV1 && $past(state_q) == S_IDLE) |-> $past(take))
		else $error("divider started without an accepted sample");

endmodule

/* test/tb_scaled_monotonic_timestamp.sv */
`timescale 1ns / 1ps

module tb_scaled_monotonic_timestamp
	import smts_pkg::*;
;

	localparam int HOLD_CYCLES = 1200;
	localparam int MAX_REPORTS = 10;

	// Tracks the register file and the last stamp, and holds the stamps still owed.
	class stamp_tracker;
		freq_t   ref_freq;
		stamp_t  ref_start;
		target_t target_hz;
		stamp_t  stamp_base;
		stamp_t  last_stamp;
		stamp_t  pending_stamps[$];
		int      mismatches;

		function new();
			ref_freq   = '0;
			ref_start  = '0;
			target_hz  = TARGET_HZ_RESET;
			stamp_base = '0;
			last_stamp = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
			case (idx)
				REG_REF_FREQ:   ref_freq  = data[FREQ_W-1:0];
				REG_REF_START:  ref_start = data;
				REG_TARGET_HZ:  target_hz = data[TARGET_W-1:0];
				REG_STAMP_BASE: begin
					stamp_base = data;
					last_stamp = data;
				end
				default: ;
			endcase
		endfunction

		// Elapsed reference ticks converted to synthetic ticks, wrapping at 64 bits.
		function stamp_t scaled_stamp(stamp_t sample);
			logic [63:0] elapsed, divisor, mult, whole, part, frac;
			divisor = 64'(ref_freq);
			mult    = 64'(target_hz);
			elapsed = sample - ref_start;
			whole   = elapsed / divisor;
			part    = elapsed % divisor;
			frac    = part * mult;
			frac    = frac / divisor;
			return stamp_base + whole * mult + frac;
		endfunction

		function void take_sample(stamp_t sample, logic ok);
			stamp_t t;
			if (ref_freq == '0 || !ok) begin
				pending_stamps = {pending_stamps, last_stamp};
				last_stamp = last_stamp + 64'd1;
			end else begin
				t = scaled_stamp(sample);
				if (t > last_stamp)
					last_stamp = t;
				pending_stamps = {pending_stamps, last_stamp};
			end
		endfunction

		function void check_stamp(stamp_t got);
			stamp_t want;
			if (pending_stamps.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: stamp word %h arrived with none owed", $time, got);
			end else begin
				want = pending_stamps.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: stamp mismatch: expected %h, got %h", $time, want, got);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 sample_valid;
	logic                 sample_stall;
	logic [63:0]          ref_sample;
	logic                 sample_ok;
	logic                 stamp_valid;
	logic                 stamp_stall;
	logic [63:0]          stamp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0]          cfg_data;

	stamp_tracker tracker;
	bit           hold_request;
	bit           sender_idles;
	bit           receiver_idles;

	scaled_monotonic_timestamp uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.ref_sample(ref_sample),
		.sample_ok(sample_ok),
		.stamp_valid(stamp_valid),
		.stamp_stall(stamp_stall),
		.stamp(stamp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic stamp_t rand64();
		return {$urandom, $urandom};
	endfunction

	// Valid is left high after a word is taken unless a random gap follows; otherwise the next call or a drain lowers it.
	task automatic send_sample(stamp_t s, logic ok);
		int gap;
		sample_valid <= 1'b1;
		ref_sample   <= s;
		sample_ok    <= ok;
		do @(posedge clk); while (sample_stall);
		tracker.take_sample(s, ok);
		gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Always lets at least one edge pass so the lowered valid is seen.
	task automatic wait_for_stamps();
		sample_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending_stamps.size() != 0);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
	endtask

	// Writes the selected registers once every owed stamp has come back.
	task automatic configure(stamp_t f, stamp_t st, stamp_t tg, stamp_t b, bit [3:0] which);
		wait_for_stamps();
		if (which[REG_REF_FREQ])
			write_cfg(REG_REF_FREQ, f);
		if (which[REG_REF_START])
			write_cfg(REG_REF_START, st);
		if (which[REG_TARGET_HZ])
			write_cfg(REG_TARGET_HZ, tg);
		if (which[REG_STAMP_BASE])
			write_cfg(REG_STAMP_BASE, b);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_setting();
		stamp_t f, st, tg, b;
		case ($urandom_range(0, 5))
			0:       f = '0;
			1:       f = 64'd1;
			2:       f = {$urandom, 32'hFFFF_FFFF};
			3:       f = 64'($urandom_range(2, 1000));
			default: f = rand64();
		endcase
		case ($urandom_range(0, 2))
			0:       st = '0;
			1:       st = '1;
			default: st = rand64();
		endcase
		case ($urandom_range(0, 5))
			0:       tg = rand64() & ~64'h3_FFFF_FFFF;
			1:       tg = rand64() | 64'h3_FFFF_FFFF;
			2:       tg = 64'(TARGET_HZ_RESET);
			default: tg = rand64();
		endcase
		case ($urandom_range(0, 2))
			0:       b = '0;
			1:       b = '1;
			default: b = rand64();
		endcase
		// Leaving the base alone now and then keeps a high last stamp across settings.
		configure(f, st, tg, b, {$urandom_range(0, 3) != 0, 3'b111});
	endtask

	// Mostly a counter moving forward from the start value, with some noise.
	task automatic run_phase(int items, int hold_at, bit pause_mid);
		stamp_t cursor;
		stamp_t step;
		int     sel;
		cursor = tracker.ref_start;
		for (int n = 0; n < items; n++) begin
			if (n == hold_at)
				hold_request = 1'b1;
			if (pause_mid && n == items / 2)
				wait_for_stamps();
			sel = $urandom_range(0, 19);
			if (sel <= 13) begin
				case ($urandom_range(0, 3))
					0:       step = 64'($urandom_range(0, 1000));
					1:       step = 64'($urandom_range(0, 1 << 20));
					2:       step = 64'($urandom);
					default: step = {24'd0, 8'($urandom_range(0, 255)), $urandom};
				endcase
				cursor = cursor + step;
				send_sample(cursor, 1'b1);
			end else if (sel <= 15) begin
				send_sample(cursor - 64'($urandom_range(1, 5000)), 1'b1);
			end else if (sel <= 17) begin
				send_sample(rand64(), 1'b0);
			end else if (sel == 18) begin
				send_sample(rand64(), 1'b1);
			end else begin
				send_sample(cursor, 1'b0);
			end
		end
	endtask

	initial begin
		#10_000_000;
		$display("FAIL scaled_monotonic_timestamp");
		$finish;
	end

	// Stamp side: checks every taken word and stalls in bursts or for a long hold-off.
	initial begin
		int stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stamp_valid && !stamp_stall)
				tracker.check_stamp(stamp);
			if (hold_request) begin
				stall_left   = HOLD_CYCLES;
				hold_request = 1'b0;
			end else if (stall_left == 0 && receiver_idles && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 7);
			end
			if (stall_left > 0) begin
				stamp_stall <= 1'b1;
				stall_left--;
			end else begin
				stamp_stall <= 1'b0;
			end
		end
	end

	initial begin
		tracker        = new();
		hold_request   = 1'b0;
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		arst_n       <= 1'b0;
		sample_valid <= 1'b0;
		ref_sample   <= '0;
		sample_ok    <= 1'b0;
		stamp_stall  <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_REF_FREQ;
		cfg_data     <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: the frequency is zero, so every word takes the increment path.
		send_sample('0, 1'b0);
		send_sample('1, 1'b1);
		send_sample(rand64(), 1'b1);

		// The last stamp loaded with all ones wraps to zero on the next increment.
		configure('0, '0, '0, '1, 4'b1000);
		send_sample('0, 1'b1);
		send_sample('0, 1'b0);

		// Counter behind the start value, and products far past 64 bits.
		configure(64'hFFFF_FFFF_0000_0001, '1, '1, '0, 4'b1111);
		send_sample('0, 1'b1);
		send_sample('1, 1'b1);
		send_sample(64'h8000_0000_0000_0000, 1'b1);
		send_sample(64'h8000_0000_0000_0001, 1'b0);

		// A zero target rate pins the result at the base.
		configure('1, '0, 64'hFFFF_FFFC_0000_0000, rand64(), 4'b1111);
		send_sample('1, 1'b1);
		send_sample(64'd12345, 1'b1);

		// Small divisor so the remainder takes every value.
		configure(64'd3, 64'd100, 64'(TARGET_HZ_RESET), '0, 4'b1111);
		for (int k = 0; k < 5; k++)
			send_sample(64'd100 + 64'(k), 1'b1);
		send_sample(64'd1 << 40, 1'b1);

		// Largest remainder times largest target overflows before the second division.
		configure('1, '0, 64'h3_FFFF_FFFF, '0, 4'b1111);
		send_sample(64'hFFFF_FFFE, 1'b1);
		send_sample(64'h1_FFFF_FFFD, 1'b1);

		for (int ph = 0; ph < 13; ph++) begin
			random_setting();
			sender_idles   = $urandom_range(0, 2) != 0;
			receiver_idles = $urandom_range(0, 2) != 0;
			run_phase(100, (ph == 2 || ph == 9) ? 20 : -1, ph == 5);
		end

		// Closing stretch at full rate on both sides.
		random_setting();
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		run_phase(150, -1, 1'b0);

		wait_for_stamps();
		repeat (150) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_stamps.size() == 0)
			$display("PASS scaled_monotonic_timestamp");
		else
			$display("FAIL scaled_monotonic_timestamp");
		$finish;
	end

endmodule
